/* src/ffa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and command codes of the first-fit arena allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int ARENA_BYTES = 4096;
  localparam int ADDR_W      = $clog2(ARENA_BYTES);
  // wide byte address: header walks may step far past the arena end
  localparam int WIDE_W      = 18;
  localparam int SIZE_W      = 13;
  localparam int HDR         = 3;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_ALLOC  = 3'd1,
    CMD_FREE   = 3'd2,
    CMD_SFREE  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_WRITE  = 3'd5
  } cmd_t;

  localparam logic REG_ARENA_SIZE = 1'b0;
  localparam logic REG_CLEAN      = 1'b1;

endpackage

/* src/ffa_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_if
// Command and response channels of the arena allocator.
// ----------------------------------------------------------------------------
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [12:0] request_size;
  logic [11:0] block_offset;
  logic [7:0]  write_data;

  modport source(output valid, cmd, request_size, block_offset, write_data, input ready);
  modport sink(input valid, cmd, request_size, block_offset, write_data, output ready);
endinterface

interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [11:0] result_offset;
  logic [7:0]  read_data;

  modport source(output valid, status, result_offset, read_data, input ready);
  modport sink(input valid, status, result_offset, read_data, output ready);
endinterface

/* src/ffa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/first_fit_arena_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// Byte arena with inline 3-byte block headers; init, first-fit alloc,
// free and merging free, single byte read and write.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command beat (cmd, request_size, block_offset,
//   write_data); rsp returns exactly one beat per command (status,
//   result_offset, read_data). The APB port sets arena_size (0x0) and
//   clean_on_free (0x4); the user must write them only while idle, as
//   the block does not enforce it. One command is worked at a time;
//   req.ready is high only when idle. All arena traffic goes through
//   one 4096 x 8 RAM port pair, one byte per cycle, under a sequencer:
//     read, write, free: a single byte read or write
//     init: clear the arena bytes, then write the free header
//     alloc: read each header walked, split if large, mark block used
//     smart free: read and merge each following free block, then
//     zero the data bytes when clean_on_free is set.
//   The response beat is held until rsp.ready; no new command is taken
//   meanwhile. Reset sets arena_size to 4096 and clean_on_free to 0; the
//   arena holds garbage until an init command.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator (
  input  logic        clk,
  input  logic        rst,
  ffa_req_if.sink     req,
  ffa_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WW = ffa_pkg::WIDE_W;

  typedef enum logic [5:0] {
    ST_IDLE, ST_INIT_CLR, ST_INIT_W0, ST_INIT_W1, ST_INIT_W2, ST_INIT_T0, ST_INIT_T1,
    ST_AL_H0, ST_AL_H1, ST_AL_H2, ST_AL_H3, ST_AL_EVAL, ST_AL_CHK,
    ST_AL_S0, ST_AL_S1, ST_AL_S2, ST_AL_S3, ST_AL_S4, ST_AL_MARK,
    ST_FR_W,
    ST_SF_CLR, ST_SF_R0, ST_SF_R1, ST_SF_R2, ST_SF_ND, ST_SF_CHK, ST_SF_USED,
    ST_SF_S2A, ST_SF_S2B, ST_SF_GCHK, ST_SF_W0, ST_SF_W1, ST_SF_W2, ST_SF_W3,
    ST_SF_END, ST_SF_CLEAN,
    ST_RD_ISS, ST_RD_CAP, ST_WR_B, ST_RESP
  } state_t;

  state_t state;

  logic [12:0]   arena_size;
  logic          clean_on_free;
  logic [12:0]   n;
  logic [12:0]   req_size;
  logic [11:0]   v;
  logic [7:0]    wdat;
  logic [WW-1:0] h;
  logic [WW-1:0] nh;
  logic [WW-1:0] nd;
  logic [WW-1:0] grown;
  logic [15:0]   size;
  logic [15:0]   rem;
  logic [7:0]    used;
  logic [7:0]    s2lo;
  logic [15:0]   cnt;
  logic          first;
  logic          oob_q;
  logic          status;
  logic [11:0]   result_offset;
  logic [7:0]    read_data;

  logic [WW-1:0] raddr;
  logic [WW-1:0] waddr;
  logic          wen;
  logic [7:0]    wbyte;
  logic [7:0]    ram_q;
  logic [7:0]    rdat;
  logic [WW-1:0] v_w;
  logic [WW-1:0] n_w;

  assign v_w  = {{(WW-12){1'b0}}, v};
  assign n_w  = {{(WW-13){1'b0}}, n};
  // bytes past the store read as zero
  assign rdat = oob_q ? 8'd0 : ram_q;

  // APB register file
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ffa_pkg::REG_CLEAN) ? {31'd0, clean_on_free}
                                                   : {19'd0, arena_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_size    <= 13'd4096;
      clean_on_free <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ffa_pkg::REG_ARENA_SIZE) begin
        arena_size <= pwdata[12:0];
      end else begin
        clean_on_free <= pwdata[0];
      end
    end
  end

  // memory port selection per sequencer step
  always_comb begin
    raddr = '0;
    waddr = '0;
    wen   = 1'b0;
    wbyte = 8'd0;
    case (state)
      ST_INIT_CLR: begin wen = 1'b1; waddr = {2'd0, cnt}; end
      ST_INIT_W0:  begin wen = 1'b1; waddr = '0; wbyte = 8'(n - 13'd3); end
      ST_INIT_W1:  begin
        wen = 1'b1; waddr = WW'(1); wbyte = {3'd0, 5'((n - 13'd3) >> 8)};
      end
      ST_INIT_W2:  begin wen = 1'b1; waddr = WW'(2); end
      ST_INIT_T0:  begin wen = 1'b1; waddr = '0; end
      ST_INIT_T1:  begin wen = 1'b1; waddr = WW'(1); end
      ST_AL_H0:    raddr = h;
      ST_AL_H1:    raddr = h + WW'(1);
      ST_AL_H2:    raddr = h + WW'(2);
      ST_AL_S0:    begin wen = 1'b1; waddr = nh; wbyte = rem[7:0]; end
      ST_AL_S1:    begin wen = 1'b1; waddr = nh + WW'(1); wbyte = rem[15:8]; end
      ST_AL_S2:    begin wen = 1'b1; waddr = nh + WW'(2); end
      ST_AL_S3:    begin wen = 1'b1; waddr = h; wbyte = req_size[7:0]; end
      ST_AL_S4:    begin
        wen = 1'b1; waddr = h + WW'(1); wbyte = {3'd0, req_size[12:8]};
      end
      ST_AL_MARK:  begin wen = 1'b1; waddr = h + WW'(2); wbyte = 8'd1; end
      ST_FR_W:     begin wen = 1'b1; waddr = v_w - WW'(1); end
      ST_SF_CLR:   begin wen = 1'b1; waddr = v_w - WW'(1); end
      ST_SF_R0:    raddr = h;
      ST_SF_R1:    raddr = h + WW'(1);
      ST_SF_CHK:   raddr = nd - WW'(1);
      ST_SF_USED:  raddr = nd - WW'(3);
      ST_SF_S2A:   raddr = nd - WW'(2);
      ST_SF_W0:    begin wen = 1'b1; waddr = h; wbyte = grown[7:0]; end
      ST_SF_W1:    begin wen = 1'b1; waddr = h + WW'(1); wbyte = grown[15:8]; end
      ST_SF_W2:    begin wen = 1'b1; waddr = nd - WW'(3); end
      ST_SF_W3:    begin wen = 1'b1; waddr = nd - WW'(2); end
      ST_SF_CLEAN: begin wen = 1'b1; waddr = v_w + {2'd0, cnt}; end
      ST_RD_ISS:   raddr = v_w;
      ST_WR_B:     begin wen = 1'b1; waddr = v_w; wbyte = wdat; end
      default:     raddr = '0;
    endcase
  end

  ffa_ram #(
    .WIDTH(8),
    .DEPTH(ffa_pkg::ARENA_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (wen && (waddr[WW-1:ffa_pkg::ADDR_W] == '0)),
    .waddr(waddr[ffa_pkg::ADDR_W-1:0]),
    .wdata(wbyte),
    .raddr(raddr[ffa_pkg::ADDR_W-1:0]),
    .rdata(ram_q)
  );

  assign req.ready         = (state == ST_IDLE);
  assign rsp.valid         = (state == ST_RESP);
  assign rsp.status        = status;
  assign rsp.result_offset = result_offset;
  assign rsp.read_data     = read_data;

  // sequencer
  always_ff @(posedge clk) begin
    oob_q <= (raddr[WW-1:ffa_pkg::ADDR_W] != '0);
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            status        <= 1'b0;
            result_offset <= 12'd0;
            read_data     <= 8'd0;
            req_size      <= req.request_size;
            v             <= req.block_offset;
            wdat          <= req.write_data;
            n             <= (arena_size > 13'd4096) ? 13'd4096 : arena_size;
            h             <= {{(WW-12){1'b0}}, req.block_offset} - WW'(ffa_pkg::HDR);
            cnt           <= 16'd0;
            first         <= 1'b1;
            case (req.cmd)
              ffa_pkg::CMD_INIT: begin
                if (((arena_size > 13'd4096) ? 13'd4096 : arena_size) <= 13'd3) begin
                  state <= ST_INIT_T0;
                end else begin
                  state <= ST_INIT_CLR;
                end
              end
              ffa_pkg::CMD_ALLOC: begin
                h     <= '0;
                state <= ST_AL_H0;
              end
              ffa_pkg::CMD_FREE:
                state <= (req.block_offset >= 12'd3) ? ST_FR_W : ST_RESP;
              ffa_pkg::CMD_SFREE:
                state <= (req.block_offset >= 12'd3) ? ST_SF_CLR : ST_RESP;
              ffa_pkg::CMD_READ:  state <= ST_RD_ISS;
              ffa_pkg::CMD_WRITE: state <= ST_WR_B;
              default:            state <= ST_RESP;
            endcase
          end
        end
        // clear the arena one byte a cycle, then lay down the free header
        ST_INIT_CLR: begin
          cnt <= cnt + 16'd1;
          if (cnt[12:0] == n - 13'd1) begin
            state <= ST_INIT_W0;
          end
        end
        ST_INIT_W0: state <= ST_INIT_W1;
        ST_INIT_W1: state <= ST_INIT_W2;
        ST_INIT_W2: state <= ST_RESP;
        ST_INIT_T0: state <= ST_INIT_T1;
        ST_INIT_T1: state <= ST_RESP;
        // fetch the header at h
        ST_AL_H0: state <= ST_AL_H1;
        ST_AL_H1: begin
          size[7:0] <= rdat;
          state     <= ST_AL_H2;
        end
        ST_AL_H2: begin
          size[15:8] <= rdat;
          state      <= ST_AL_H3;
        end
        ST_AL_H3: begin
          used <= rdat;
          if (first && (size == 16'd0)) begin
            status <= 1'b1;
            state  <= ST_RESP;
          end else begin
            state <= ST_AL_EVAL;
          end
        end
        // first fit: take the block or step to the next header
        ST_AL_EVAL: begin
          first <= 1'b0;
          if ((used != 8'd0) || (size < {3'd0, req_size})) begin
            h     <= h + {2'd0, size} + WW'(ffa_pkg::HDR);
            state <= ST_AL_CHK;
          end else if ((size - {3'd0, req_size}) > 16'd3) begin
            nh    <= h + WW'(ffa_pkg::HDR) + {5'd0, req_size};
            rem   <= size - {3'd0, req_size} - 16'd3;
            state <= ST_AL_S0;
          end else begin
            state <= ST_AL_MARK;
          end
        end
        ST_AL_CHK: begin
          if ((h + WW'(ffa_pkg::HDR)) >= n_w) begin
            status <= 1'b1;
            state  <= ST_RESP;
          end else begin
            state <= ST_AL_H0;
          end
        end
        ST_AL_S0: state <= ST_AL_S1;
        ST_AL_S1: state <= ST_AL_S2;
        ST_AL_S2: state <= ST_AL_S3;
        ST_AL_S3: state <= ST_AL_S4;
        ST_AL_S4: state <= ST_AL_MARK;
        ST_AL_MARK: begin
          result_offset <= h[11:0] + 12'd3;
          state         <= ST_RESP;
        end
        ST_FR_W: state <= ST_RESP;
        // merging free: read own size, test and merge the next block
        ST_SF_CLR: state <= ST_SF_R0;
        ST_SF_R0:  state <= ST_SF_R1;
        ST_SF_R1: begin
          size[7:0] <= rdat;
          state     <= ST_SF_R2;
        end
        ST_SF_R2: begin
          size[15:8] <= rdat;
          state      <= ST_SF_ND;
        end
        ST_SF_ND: begin
          nd    <= v_w + {2'd0, size} + WW'(ffa_pkg::HDR);
          state <= ST_SF_CHK;
        end
        ST_SF_CHK: state <= (nd >= n_w) ? ST_SF_END : ST_SF_USED;
        ST_SF_USED: state <= (rdat != 8'd0) ? ST_SF_END : ST_SF_S2A;
        ST_SF_S2A: begin
          s2lo  <= rdat;
          state <= ST_SF_S2B;
        end
        ST_SF_S2B: begin
          grown <= {2'd0, size} + {2'd0, rdat, s2lo} + WW'(ffa_pkg::HDR);
          state <= ST_SF_GCHK;
        end
        ST_SF_GCHK: state <= ((v_w + grown) > n_w) ? ST_SF_END : ST_SF_W0;
        ST_SF_W0: state <= ST_SF_W1;
        ST_SF_W1: state <= ST_SF_W2;
        ST_SF_W2: state <= ST_SF_W3;
        ST_SF_W3: state <= ST_SF_R0;
        ST_SF_END: begin
          cnt   <= 16'd0;
          state <= (clean_on_free && (size != 16'd0)) ? ST_SF_CLEAN : ST_RESP;
        end
        // zero the data bytes one a cycle
        ST_SF_CLEAN: begin
          cnt <= cnt + 16'd1;
          if ((cnt + 16'd1) == size) begin
            state <= ST_RESP;
          end
        end
        ST_RD_ISS: state <= ST_RD_CAP;
        ST_RD_CAP: begin
          read_data <= rdat;
          state     <= ST_RESP;
        end
        ST_WR_B: state <= ST_RESP;
        // hold the response beat until taken
        ST_RESP: begin
          if (rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
